// ----- sv/ida_pkg.sv -----
// Shared constants, operation codes and control structs for the identifier allocator.
package ida_pkg;

   localparam int MAX_IDS_DEF  = 1024;
   localparam int SIG_BITS_DEF = 32;

   localparam int               CHUNK_W     = 11;
   localparam logic [CHUNK_W-1:0] CHUNK_RESET = 11'd100;

   localparam int OP_W   = 3;
   localparam int USER_W = OP_W + 1;

   localparam logic [OP_W-1:0] OP_ALLOC = 3'd0;
   localparam logic [OP_W-1:0] OP_FREE  = 3'd1;
   localparam logic [OP_W-1:0] OP_SET   = 3'd2;
   localparam logic [OP_W-1:0] OP_GET   = 3'd3;
   localparam logic [OP_W-1:0] OP_QUERY = 3'd4;

   typedef struct packed {
      logic alloc;
      logic free;
   } pool_cmd_type;

   typedef struct packed {
      logic have;
      logic take_fresh;
   } pool_flags_type;

endpackage

// ----- sv/ida_pool.sv -----
// Pool bookkeeping: fresh range, chunk extension, freed-queue pointers and live count.
module ida_pool #(
   parameter int MAX_IDS = ida_pkg::MAX_IDS_DEF,
   parameter int ID_W    = $clog2(MAX_IDS),
   parameter int CNT_W   = $clog2(MAX_IDS + 1)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [ida_pkg::CHUNK_W-1:0]  chunk_size,
   input  ida_pkg::pool_cmd_type        cmd,
   output ida_pkg::pool_flags_type      flags,
   output logic [CNT_W-1:0]             next_fresh,
   output logic [CNT_W-1:0]             pool_end,
   output logic [ID_W-1:0]              head,
   output logic [ID_W-1:0]              tail,
   output logic [CNT_W-1:0]             fill,
   output logic [CNT_W-1:0]             live_next
);

   localparam int EXT_W = (CNT_W > ida_pkg::CHUNK_W) ? CNT_W : ida_pkg::CHUNK_W;
   localparam int END_RESET = (int'(ida_pkg::CHUNK_RESET) < MAX_IDS) ?
                              int'(ida_pkg::CHUNK_RESET) : MAX_IDS;

   logic [CNT_W-1:0] fresh_ff, fresh_in;
   logic [CNT_W-1:0] end_ff, end_in;
   logic [ID_W-1:0]  head_ff, head_in;
   logic [ID_W-1:0]  tail_ff, tail_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [CNT_W-1:0] live_ff, live_in;

   logic             need_ext;
   logic [CNT_W-1:0] room;
   logic [EXT_W-1:0] chunk_ext, room_ext, amount_ext;
   logic [CNT_W-1:0] amount;
   logic [CNT_W-1:0] end_ext;

   function automatic logic [ID_W-1:0] wrap_inc(input logic [ID_W-1:0] p);
      return (p == ID_W'(MAX_IDS - 1)) ? '0 : p + 1'b1;
   endfunction

   always_comb begin
      need_ext   = (fresh_ff >= end_ff) && (fill_ff == '0);
      room       = CNT_W'(MAX_IDS) - end_ff;
      chunk_ext  = EXT_W'(chunk_size);
      room_ext   = EXT_W'(room);
      amount_ext = (chunk_ext < room_ext) ? chunk_ext : room_ext;
      amount     = amount_ext[CNT_W-1:0];
      end_ext    = need_ext ? end_ff + amount : end_ff;

      flags.have       = !need_ext || (amount != '0);
      flags.take_fresh = fresh_ff < end_ext;

      fresh_in = fresh_ff;
      end_in   = end_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      fill_in  = fill_ff;
      live_in  = live_ff;

      if (cmd.alloc) begin
         end_in  = end_ext;
         live_in = live_ff + 1'b1;
         if (flags.take_fresh) begin
            fresh_in = fresh_ff + 1'b1;
         end else begin
            head_in = wrap_inc(head_ff);
            fill_in = fill_ff - 1'b1;
         end
      end else if (cmd.free) begin
         tail_in = wrap_inc(tail_ff);
         fill_in = fill_ff + 1'b1;
         if (live_ff != '0) begin
            live_in = live_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fresh_ff <= '0;
         end_ff   <= CNT_W'(END_RESET);
         head_ff  <= '0;
         tail_ff  <= '0;
         fill_ff  <= '0;
         live_ff  <= '0;
      end else begin
         fresh_ff <= fresh_in;
         end_ff   <= end_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         fill_ff  <= fill_in;
         live_ff  <= live_in;
      end
   end

   assign next_fresh = fresh_ff;
   assign pool_end   = end_ff;
   assign head       = head_ff;
   assign tail       = tail_ff;
   assign fill       = fill_ff;
   assign live_next  = live_in;

endmodule

// ----- sv/id_allocator_with_signatures_top.sv -----
// Top level of the identifier allocator: sequencer, entry and freed-queue memories, result register.
//
//  channel | dir | handshake            | payload
//  csr     | in  | csr_valid/csr_ready  | csr_data = chunk_size
//  req     | in  | req_tvalid/tready    | tuser = op, id_valid; tdata = entity_id, sig_value
//  rsp     | out | rsp_tvalid/tready    | tdata = ok, given_id, sig_read, is_active, live_count
//
// Each transfer is accepted in idle, then executed on the registered memory read;
// an allocate that reuses a freed identifier adds a pop step, as the entry of the popped
// identifier needs its own read. After reset a clearing pass over all MAX_IDS entries zeroes
// the entry memory; req_tready stays low during it. A result waits in the output
// register; a finished operation holds in execute or pop while that register is still full.
module id_allocator_with_signatures_top #(
   parameter int MAX_IDS  = ida_pkg::MAX_IDS_DEF,
   parameter int SIG_BITS = ida_pkg::SIG_BITS_DEF,
   parameter int ID_W     = $clog2(MAX_IDS),
   parameter int CNT_W    = $clog2(MAX_IDS + 1),
   parameter int REQ_DW   = ((ID_W + SIG_BITS + 7) / 8) * 8,
   parameter int RSP_DW   = ((2 + ID_W + SIG_BITS + CNT_W + 7) / 8) * 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [ida_pkg::CHUNK_W-1:0]  csr_data,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [REQ_DW-1:0]            req_tdata,  // entity_id, sig_value
   input  logic [ida_pkg::USER_W-1:0]   req_tuser,  // op, id_valid
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [RSP_DW-1:0]            rsp_tdata   // ok, given_id, sig_read, is_active, live_count
);

   localparam int ENT_W = SIG_BITS + 1;

   typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_EXEC, S_POP} state_type;

   state_type state_ff, state_in;
   logic [ID_W-1:0] clr_ff, clr_in;

   logic [ida_pkg::CHUNK_W-1:0] chunk_ff;

   logic [ENT_W-1:0] ent_mem [MAX_IDS];
   logic [ID_W-1:0]  que_mem [MAX_IDS];
   logic [ENT_W-1:0] ent_rd_ff;
   logic [ID_W-1:0]  que_rd_ff;

   logic             ent_we;
   logic [ID_W-1:0]  ent_waddr, ent_raddr;
   logic [ENT_W-1:0] ent_wdata;
   logic             que_we;

   logic [ida_pkg::OP_W-1:0] op_ff;
   logic                     id_ok_ff;
   logic [ID_W-1:0]          id_ff;
   logic [SIG_BITS-1:0]      sig_ff;
   logic [ID_W-1:0]          pop_id_ff;

   logic                rsp_valid_ff;
   logic                ok_ff, ok_in;
   logic [ID_W-1:0]     given_ff, given_in;
   logic [SIG_BITS-1:0] sigr_ff, sigr_in;
   logic                act_ff, act_in;
   logic [CNT_W-1:0]    live_ff;

   logic                req_fire, finish, out_free;
   logic [ida_pkg::OP_W-1:0] req_op;
   logic                req_idv;
   logic [ID_W-1:0]     req_id;
   logic [SIG_BITS-1:0] req_sig;

   logic                ent_flag;
   logic [SIG_BITS-1:0] ent_sig;
   logic                in_pool;
   logic                free_ok;

   ida_pkg::pool_cmd_type   cmd;
   ida_pkg::pool_flags_type flags;
   logic [CNT_W-1:0] next_fresh, pool_end, fill, live_next;
   logic [ID_W-1:0]  head, tail;

   ida_pool #(
      .MAX_IDS (MAX_IDS),
      .ID_W    (ID_W),
      .CNT_W   (CNT_W)
   ) u_pool (
      .clock      (clock),
      .reset      (reset),
      .chunk_size (chunk_ff),
      .cmd        (cmd),
      .flags      (flags),
      .next_fresh (next_fresh),
      .pool_end   (pool_end),
      .head       (head),
      .tail       (tail),
      .fill       (fill),
      .live_next  (live_next)
   );

   assign req_op  = req_tuser[ida_pkg::OP_W-1:0];
   assign req_idv = req_tuser[ida_pkg::OP_W];
   assign req_id  = req_tdata[ID_W-1:0];
   assign req_sig = req_tdata[ID_W+SIG_BITS-1:ID_W];

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign csr_ready  = 1'b1;

   assign ent_flag = ent_rd_ff[SIG_BITS];
   assign ent_sig  = ent_rd_ff[SIG_BITS-1:0];
   assign in_pool  = ent_flag ||
                     ((CNT_W'(id_ff) >= next_fresh) && (CNT_W'(id_ff) < pool_end));
   assign free_ok  = id_ok_ff && (CNT_W'(id_ff) < pool_end) && !in_pool &&
                     (fill < CNT_W'(MAX_IDS));

   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      finish    = 1'b0;
      ok_in     = 1'b0;
      given_in  = '0;
      sigr_in   = '0;
      act_in    = 1'b0;
      ent_we    = 1'b0;
      ent_waddr = id_ff;
      ent_wdata = '0;
      ent_raddr = id_ff;
      que_we    = 1'b0;
      cmd       = '0;

      unique case (state_ff)
         S_CLEAR: begin
            ent_we    = 1'b1;
            ent_waddr = clr_ff;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == ID_W'(MAX_IDS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            ent_raddr = req_id;
            if (req_fire) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (op_ff == ida_pkg::OP_ALLOC) begin
               ent_raddr = que_rd_ff;
               if (flags.have && !flags.take_fresh) begin
                  cmd.alloc = 1'b1;
                  state_in  = S_POP;
               end else if (out_free) begin
                  finish    = 1'b1;
                  state_in  = S_IDLE;
                  cmd.alloc = flags.have;
                  ok_in     = flags.have;
                  given_in  = flags.have ? next_fresh[ID_W-1:0] : '0;
               end
            end else if (out_free) begin
               finish   = 1'b1;
               state_in = S_IDLE;
               unique case (op_ff)
                  ida_pkg::OP_FREE: begin
                     ok_in = free_ok;
                     if (free_ok) begin
                        ent_we    = 1'b1;
                        ent_wdata = {1'b1, {SIG_BITS{1'b0}}};
                        que_we    = 1'b1;
                        cmd.free  = 1'b1;
                     end
                  end
                  ida_pkg::OP_SET: begin
                     ok_in = id_ok_ff;
                     if (id_ok_ff) begin
                        ent_we    = 1'b1;
                        ent_wdata = {ent_flag, sig_ff};
                     end
                  end
                  ida_pkg::OP_GET: begin
                     ok_in   = id_ok_ff;
                     sigr_in = id_ok_ff ? ent_sig : '0;
                  end
                  ida_pkg::OP_QUERY: begin
                     ok_in  = id_ok_ff;
                     act_in = id_ok_ff && !in_pool;
                  end
                  default: begin
                     ok_in = 1'b0;
                  end
               endcase
            end
         end
         S_POP: begin
            ent_raddr = pop_id_ff;
            ent_waddr = pop_id_ff;
            if (out_free) begin
               finish    = 1'b1;
               state_in  = S_IDLE;
               ent_we    = 1'b1;
               ent_wdata = {1'b0, ent_sig};
               ok_in     = 1'b1;
               given_in  = pop_id_ff;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         if (finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (req_fire) begin
         op_ff    <= req_op;
         id_ok_ff <= req_idv && (CNT_W'(req_id) < CNT_W'(MAX_IDS));
         id_ff    <= req_id;
         sig_ff   <= req_sig;
      end
      if (cmd.alloc && !flags.take_fresh) begin
         pop_id_ff <= que_rd_ff;
      end
      if (finish) begin
         ok_ff    <= ok_in;
         given_ff <= given_in;
         sigr_ff  <= sigr_in;
         act_ff   <= act_in;
         live_ff  <= live_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_ff <= ida_pkg::CHUNK_RESET;
      end else if (csr_valid && csr_ready) begin
         chunk_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (ent_we) begin
         ent_mem[ent_waddr] <= ent_wdata;
      end
      ent_rd_ff <= ent_mem[ent_raddr];
   end

   always_ff @(posedge clock) begin
      if (que_we) begin
         que_mem[tail] <= id_ff;
      end
      que_rd_ff <= que_mem[head];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DW'({live_ff, act_ff, sigr_ff, given_ff, ok_ff});

endmodule
